@@ sv/smsc_pkg.sv @@
// ----------------------------------------------------------------------------
// smsc_pkg: shared types and constants
// Beat structures and sizing constants for the sample statistics core.
// ----------------------------------------------------------------------------
package smsc_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;

	// One input beat.
	typedef struct packed {
		logic signed [31:0] sample;
		logic               last;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic signed [31:0] mean;
		logic        [30:0] std_dev;
		logic signed [31:0] coeff_var;
		logic               sd_invalid;
		logic               cov_invalid;
		logic               overflowed;
	} out_beat_t;

	// Job handed from the front end to the back end when a set closes.
	typedef struct packed {
		logic signed [47:0] sum;
		logic        [10:0] count;
		logic               ovf;
	} job_t;

endpackage

@@ sv/sample_mean_sd_cov_core.sv @@
// ----------------------------------------------------------------------------
// sample_mean_sd_cov_core: mean, sd and cov of one vertex's samples
// Front end stores samples; back end computes the statistics of a set.
// ----------------------------------------------------------------------------
// A sample beat is taken while busy is low, so samples may follow back to
// back. A beat with last set closes the set and raises busy; the result
// strobe on done follows a division for the mean, a sweep over the stored
// samples, a division for the variance, a square root and a division for the
// cov. The root steps are skipped when the variance is too large for the
// square root and the sd saturates. Busy falls in the cycle that shows the
// result; done is high for a single cycle and cannot be held off, while the
// result values stay on the ports until the next result.
module sample_mean_sd_cov_core #(
	parameter int MAX_SAMPLES = smsc_pkg::MAX_SAMPLES_DEF,
	parameter int FRAC_BITS   = smsc_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  smsc_pkg::in_beat_t  in_beat,
	output logic                done,
	output smsc_pkg::out_beat_t result
);

	localparam int AW = $clog2(MAX_SAMPLES);

	logic                job_valid;
	smsc_pkg::job_t      job;
	logic [AW-1:0]       rd_addr;
	logic signed [31:0]  rd_data;
	logic                idle;
	logic                pend_q;

	// Busy from the closing beat until the back end is idle again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (start && !busy && in_beat.last) pend_q <= 1'b1;
		else if (idle && !job_valid) pend_q <= 1'b0;
	end
	assign busy = pend_q && !(idle && !job_valid) || job_valid || !idle;

	smsc_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk, .arst_n, .in_valid(start && !busy), .in_beat,
		.job_valid, .job, .rd_addr, .rd_data
	);

	smsc_back #(.MAX_SAMPLES(MAX_SAMPLES), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .job_valid, .job, .idle, .rd_addr, .rd_data,
		.done, .res(result)
	);

endmodule

@@ sv/smsc_front.sv @@
// ----------------------------------------------------------------------------
// smsc_front: sample intake
// Stores samples, keeps the running sum and count, and posts a job on last.
// ----------------------------------------------------------------------------
module smsc_front #(
	parameter int MAX_SAMPLES = smsc_pkg::MAX_SAMPLES_DEF,
	localparam int AW = $clog2(MAX_SAMPLES),
	localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  smsc_pkg::in_beat_t  in_beat,
	output logic                job_valid,
	output smsc_pkg::job_t      job,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [31:0]  rd_data
);

	logic signed [31:0] mem [MAX_SAMPLES];
	logic signed [47:0] sum_q;
	logic [CW-1:0]      cnt_q;
	logic               ovf_q;
	logic               room;
	logic signed [47:0] sum_nx;
	logic [CW-1:0]      cnt_nx;
	logic               ovf_nx;

	assign room   = cnt_q < CW'(MAX_SAMPLES);
	assign sum_nx = room ? sum_q + 48'(in_beat.sample) : sum_q;
	assign cnt_nx = room ? cnt_q + CW'(1) : cnt_q;
	assign ovf_nx = ovf_q | ~room;

	// Sample buffer, written at the fill count.
	always_ff @(posedge clk) begin
		if (in_valid && room)
			mem[cnt_q[AW-1:0]] <= in_beat.sample;
		rd_data <= mem[rd_addr];
	end

	// Running totals; a last beat hands them over and starts afresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= in_valid && in_beat.last;
			if (in_valid) begin
				if (in_beat.last) begin
					sum_q <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_nx;
					cnt_q <= cnt_nx;
					ovf_q <= ovf_nx;
				end
			end
		end
	end

	// Job payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_beat.last) begin
			job.sum   <= sum_nx;
			job.count <= 11'(cnt_nx);
			job.ovf   <= ovf_nx;
		end
	end

endmodule

@@ sv/smsc_back.sv @@
// ----------------------------------------------------------------------------
// smsc_back: statistics sequencer
// Divides for the mean, sweeps the buffer for squared deviations, then
// divides, takes the square root and divides again for the cov.
// ----------------------------------------------------------------------------
module smsc_back #(
	parameter int MAX_SAMPLES = smsc_pkg::MAX_SAMPLES_DEF,
	parameter int FRAC_BITS   = smsc_pkg::FRAC_BITS_DEF,
	localparam int AW = $clog2(MAX_SAMPLES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  smsc_pkg::job_t      job,
	output logic                idle,
	output logic [AW-1:0]       rd_addr,
	input  logic signed [31:0]  rd_data,
	output logic                done,
	output smsc_pkg::out_beat_t res
);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_MDIV = 4'd1, ST_SWEEP = 4'd2,
		ST_SQ = 4'd3, ST_ACC = 4'd4, ST_VDIV = 4'd5, ST_SQRT = 4'd6,
		ST_CDIV = 4'd7, ST_OUT = 4'd8;

	logic [3:0]          st_q;
	smsc_pkg::job_t      job_q;
	// Shared restoring divider: 128-bit dividend, 48-bit divisor.
	logic [127:0]        dq_q;
	logic [47:0]         dr_q;
	logic [47:0]         dd_q;
	logic [7:0]          it_q;
	logic [48:0]         trial;
	logic signed [47:0]  mean_q;
	logic [47:0]         am_q;
	logic [10:0]         idx_q;
	logic [10:0]         seen_q;
	logic signed [48:0]  dev_s1;
	// A deviation never exceeds the span of two 32-bit samples.
	logic [31:0]         mag;
	logic [63:0]         sq_s2;
	logic [127:0]        acc_q;
	logic [63:0]         sv_q;
	logic [63:0]         srem_q;
	logic [31:0]         root_q;
	logic [33:0]         strial;
	logic [30:0]         sd_q;
	logic                sdinv_q;
	logic                covinv_q;
	logic [6:0]          step_q;
	logic [63:0]         q;

	assign idle    = st_q == ST_IDLE;
	assign rd_addr = idx_q[AW-1:0];
	assign trial   = {dr_q, dq_q[127]} - {1'b0, dd_q};
	assign mag     = 32'(dev_s1[48] ? -dev_s1 : dev_s1);
	assign strial  = {srem_q[31:0], sv_q[63:62]} - {root_q, 2'b01};
	assign q       = dq_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
			ST_IDLE: if (job_valid) st_q <= ST_MDIV;
			ST_MDIV: if (it_q == 8'd128) st_q <= ST_SWEEP;
			ST_SWEEP: st_q <= ST_SQ;
			ST_SQ: st_q <= ST_ACC;
			ST_ACC: if (seen_q == job_q.count) st_q <= ST_VDIV;
			ST_VDIV: if (it_q == 8'd128) st_q <= ST_SQRT;
			ST_SQRT: if (step_q == 7'd32) st_q <= ST_CDIV;
			ST_CDIV: if (it_q == 8'd128) st_q <= ST_OUT;
			ST_OUT: begin
				st_q <= ST_IDLE;
				done <= 1'b1;
			end
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath of the sequencer.
	always_ff @(posedge clk) begin
		case (st_q)
		ST_IDLE: begin
			job_q <= job;
			// Dividend is |sum|, divisor is n.
			dq_q  <= {80'd0, job.sum[47] ? -job.sum : job.sum};
			dd_q  <= 48'(job.count);
			dr_q  <= '0;
			it_q  <= '0;
			acc_q <= '0;
			idx_q <= '0;
			seen_q <= '0;
		end
		ST_MDIV, ST_VDIV, ST_CDIV: begin
			if (it_q != 8'd128) begin
				if (!trial[48]) begin
					dr_q <= trial[47:0];
					dq_q <= {dq_q[126:0], 1'b1};
				end else begin
					dr_q <= {dr_q[46:0], dq_q[127]};
					dq_q <= {dq_q[126:0], 1'b0};
				end
				it_q <= it_q + 8'd1;
			end else if (st_q == ST_MDIV) begin
				mean_q  <= job_q.sum[47] ? -$signed(dq_q[47:0]) : $signed(dq_q[47:0]);
				am_q    <= dq_q[47:0];
				sdinv_q <= job_q.count < 11'd2;
				idx_q   <= 11'd1;
			end else if (st_q == ST_VDIV) begin
				sv_q   <= (dq_q[127:64] != 0 || dq_q[63:62] != 0) ? 64'd0 : dq_q[63:0];
				sd_q   <= 31'h7FFFFFFF;
				srem_q <= '0;
				// A variance beyond the root's range skips the root and saturates the sd.
				root_q <= (dq_q[127:64] != 0 || dq_q[63:62] != 0) ? 32'hFFFF_FFFF : 32'd0;
				step_q <= (dq_q[127:64] != 0 || dq_q[63:62] != 0) ? 7'd64 : 7'd0;
			end
		end
		ST_SWEEP, ST_SQ, ST_ACC: begin
			// Read, subtract, square and sum, one sample a cycle.
			if (idx_q < job_q.count) idx_q <= idx_q + 11'd1;
			dev_s1 <= 49'(rd_data) - 49'(mean_q);
			sq_s2  <= mag * mag;
			if (st_q == ST_ACC && seen_q != job_q.count) begin
				acc_q  <= acc_q + 128'(sq_s2);
				seen_q <= seen_q + 11'd1;
			end
			if (st_q == ST_ACC && seen_q == job_q.count) begin
				dq_q <= acc_q;
				dd_q <= sdinv_q ? 48'd1 : 48'(job_q.count - 11'd1);
				dr_q <= '0;
				it_q <= '0;
			end
		end
		ST_SQRT: begin
			// One root bit a cycle.
			if (step_q < 7'd32) begin
				if (!strial[33]) begin
					srem_q <= 64'(strial[33:0]);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= {srem_q[61:0], sv_q[63:62]};
					root_q <= {root_q[30:0], 1'b0};
				end
				sv_q   <= {sv_q[61:0], 2'b00};
				step_q <= step_q + 7'd1;
			end else begin
				if (step_q == 7'd32) sd_q <= sdinv_q ? 31'd0 :
					(root_q[31] ? 31'h7FFFFFFF : root_q[30:0]);
				covinv_q <= sdinv_q || mean_q == 0;
			end
			if (step_q == 7'd64) step_q <= 7'd32;
			if (step_q == 7'd32)
				dq_q <= 128'({(sdinv_q ? 31'd0 : (root_q[31] ? 31'h7FFFFFFF :
					root_q[30:0]))}) << FRAC_BITS;
			else
				dq_q <= {65'd0, sd_q, 32'd0} >> (32 - FRAC_BITS);
			dd_q <= (am_q == 0) ? 48'd1 : am_q;
			dr_q <= '0;
			it_q <= '0;
		end
		ST_OUT: begin
			res.mean        <= mean_q[31:0];
			res.std_dev     <= sd_q;
			res.sd_invalid  <= sdinv_q;
			res.cov_invalid <= covinv_q;
			res.overflowed  <= job_q.ovf;
			if (covinv_q)
				res.coeff_var <= '0;
			else if (!mean_q[47])
				res.coeff_var <= (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
			else
				res.coeff_var <= (q > 64'h80000000) ? 32'h80000000 : -q[31:0];
		end
		default: ;
		endcase
	end

endmodule

@@ sv/smsc_checker.sv @@
// ----------------------------------------------------------------------------
// smsc_checker: port checks for the statistics core
// Watches the handshake and the result flags.
// ----------------------------------------------------------------------------
module smsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input smsc_pkg::in_beat_t  in_beat,
	input logic                done,
	input smsc_pkg::out_beat_t result
);

	// A closing beat makes the core busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_beat.last |=> busy) else $error("not busy");
	// A result strobe lasts a single cycle.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("long result strobe");
	// An invalid sd marks the cov invalid too.
	a_cov: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.sd_invalid |-> result.cov_invalid) else $error("cov flag");
	// Invalid cov reads as zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.cov_invalid |-> result.coeff_var == 0) else $error("cov value");

endmodule

bind sample_mean_sd_cov_core smsc_checker u_chk (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for sample_mean_sd_cov_core
// Sends sets of samples with a closing flag, predicts mean, standard
// deviation and coefficient of variation per set, and checks each result beat.
// ----------------------------------------------------------------------------

// Keeps the running state of the open set and the queue of expected results.
class stats_scoreboard;
	logic signed [31:0]   samples[$];
	logic signed [37:0]   sum;
	bit                   dropped;
	smsc_pkg::out_beat_t  pending[$];
	int                   mismatches;
	int                   results_seen;
	int                   sets_closed;
	int                   drops_seen;

	function void clear_set();
		samples.delete();
		sum     = '0;
		dropped = 1'b0;
	endfunction

	// Floor square root of an unsigned value below 2^62, bit by bit.
	function logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Notes one accepted sample beat; on the closing beat works out the result.
	function void note_sample(smsc_pkg::in_beat_t b);
		smsc_pkg::out_beat_t  r;
		int                   n;
		logic signed [63:0]   avg;
		logic signed [63:0]   dev;
		logic [127:0]         sq_sum;
		logic [127:0]         var_q;
		logic [63:0]          sd;
		logic [63:0]          mag;
		logic [63:0]          q;
		if (samples.size() < smsc_pkg::MAX_SAMPLES_DEF) begin
			samples = {samples, b.sample};
			sum = sum + 38'(b.sample);
		end else begin
			dropped = 1'b1;
			drops_seen++;
		end
		if (!b.last)
			return;
		n   = samples.size();
		avg = 64'(sum) / n;
		sd  = '0;
		q   = '0;
		if (n >= 2) begin
			sq_sum = '0;
			foreach (samples[i]) begin
				dev    = 64'(samples[i]) - avg;
				mag    = dev < 0 ? -dev : dev;
				sq_sum = sq_sum + 128'(mag) * 128'(mag);
			end
			var_q = sq_sum / (n - 1);
			if (var_q >= (128'd1 << 62))
				sd = 64'h7FFF_FFFF;
			else
				sd = floor_sqrt(var_q[63:0]);
			if (sd > 64'h7FFF_FFFF)
				sd = 64'h7FFF_FFFF;
		end
		r.mean        = avg[31:0];
		r.std_dev     = sd[30:0];
		r.sd_invalid  = (n < 2);
		r.cov_invalid = (n < 2) || (avg == 0);
		r.overflowed  = dropped;
		r.coeff_var   = '0;
		if (!r.cov_invalid) begin
			mag = avg < 0 ? -avg : avg;
			q   = (sd << smsc_pkg::FRAC_BITS_DEF) / mag;
			if (avg > 0)
				r.coeff_var = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			else
				r.coeff_var = (q > 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		end
		pending = {pending, r};
		sets_closed++;
		clear_set();
	endfunction

	// Compares one result beat with the oldest expectation.
	function void check_result(smsc_pkg::out_beat_t got);
		smsc_pkg::out_beat_t want;
		results_seen++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat %h", got);
			return;
		end
		want = pending.pop_front();
		if (got.mean !== want.mean || got.std_dev !== want.std_dev ||
		    got.coeff_var !== want.coeff_var || got.sd_invalid !== want.sd_invalid ||
		    got.cov_invalid !== want.cov_invalid || got.overflowed !== want.overflowed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: mean %h/%h sd %h/%h cov %h/%h flags %b%b%b/%b%b%b",
					want.mean, got.mean, want.std_dev, got.std_dev,
					want.coeff_var, got.coeff_var, want.sd_invalid, want.cov_invalid,
					want.overflowed, got.sd_invalid, got.cov_invalid, got.overflowed);
		end
	endfunction
endclass

module tb_top;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	smsc_pkg::in_beat_t   in_beat;
	logic                 done;
	smsc_pkg::out_beat_t  result;

	stats_scoreboard sb;
	int              beats_sent;

	sample_mean_sd_cov_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_beat (in_beat),
		.done    (done),
		.result  (result)
	);

	// 8 ns clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result beats are taken on every edge at which done is high.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Drives one sample beat after a random gap and waits until it is taken.
	// Start stays high straight into the next beat when there is no gap.
	task automatic send_sample(logic signed [31:0] value, logic is_last);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		in_beat <= '{sample: value, last: is_last};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_sample('{sample: value, last: is_last});
		beats_sent++;
	endtask

	// Picks a sample value: mostly moderate, sometimes extreme or fully random.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			2:       return $signed($urandom_range(0, 64)) - 32;
			default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	// Sends a whole set of the given size.
	task automatic send_set(int n, logic signed [31:0] base, bit fixed);
		for (int i = 0; i < n; i++)
			send_sample(fixed ? base : pick_value(), i == n - 1);
	endtask

	initial begin
		int n;
		sb         = new();
		sb.clear_set();
		beats_sent = 0;
		start      = 1'b0;
		in_beat    = '0;
		arst_n     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: single samples, extremes, zero mean, a constant set.
		send_set(1, 32'sh7FFF_FFFF, 1'b1);
		send_set(1, 32'sh8000_0000, 1'b1);
		send_set(1, 32'sh0, 1'b1);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh0001_0000, 1'b0);
		send_sample(-32'sh0001_0000, 1'b1);
		send_set(3, 32'sh0002_8000, 1'b1);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b1);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh0000_0001, 1'b0);
		send_sample(32'sh0000_0003, 1'b1);

		// Random sets, mostly small, a few filling or overrunning the buffer.
		while (beats_sent < 490) begin
			case ($urandom_range(0, 9))
				0:       n = $urandom_range(smsc_pkg::MAX_SAMPLES_DEF,
						smsc_pkg::MAX_SAMPLES_DEF + 5);
				1:       n = 1;
				default: n = $urandom_range(2, 12);
			endcase
			if ($urandom_range(0, 7) == 0)
				send_set(n, pick_value(), 1'b1);
			else
				send_set(n, 32'sh0, 1'b0);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d sample beats in %0d sets, %0d dropped beyond capacity.",
			beats_sent, sb.sets_closed, sb.drops_seen);
		$display("Checked %0d result beats, %0d mismatches.", sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASS sample_mean_sd_cov_core");
		else
			$display("FAIL sample_mean_sd_cov_core");
		$finish;
	end

	// Watchdog.
	initial begin
		#(8 * 2000000);
		$display("FAIL sample_mean_sd_cov_core");
		$finish;
	end
endmodule
